// ===== rtl/cmmt_pkg.sv =====
// Package for the complex matrix magnitude transform unit.
// Holds sizes, operation codes, payload structs and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmmt_pkg;

   // Store sizes
   localparam int unsigned ROWS    = 64;
   localparam int unsigned SAMPLES = 256;

   // Field widths fixed by the item format
   localparam int unsigned MAG_W = 24;

   // Derived widths
   localparam int unsigned ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned ROW_CNT_W = $clog2(ROWS + 1);
   localparam int unsigned SIDX_W    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int unsigned SCNT_W    = $clog2(SAMPLES + 1);
   localparam int unsigned CDEPTH    = ROWS * SAMPLES;
   localparam int unsigned CADDR_W   = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
   localparam int unsigned PROD_W    = 32;
   localparam int unsigned ACC_W     = PROD_W + $clog2(SAMPLES);
   localparam int unsigned FRAC_W    = 15;
   localparam int unsigned A_W       = ACC_W - FRAC_W;
   localparam int unsigned SQ_W      = 2 * A_W;
   localparam int unsigned ROOT_W    = A_W + 1;
   localparam int unsigned RAD_W     = 2 * ROOT_W;
   localparam int unsigned REM_W     = ROOT_W + 2;
   localparam int unsigned RCNT_W    = $clog2(ROOT_W);

   // Operation codes
   localparam logic [1:0] OP_LOAD_COEF   = 2'd0;
   localparam logic [1:0] OP_LOAD_SAMPLE = 2'd1;
   localparam logic [1:0] OP_RUN         = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [5:0]         load_row;
      logic [7:0]         load_column;
      logic signed [15:0] coef_real;
      logic signed [15:0] coef_imag;
      logic signed [15:0] sample_value;
      logic [5:0]         row_start;
      logic [6:0]         row_end;
      logic [7:0]         sample_start;
      logic [8:0]         sample_end;
   } req_payload_type;

   typedef struct packed {
      logic [5:0]       row_index;
      logic [MAG_W-1:0] magnitude;
      logic             last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ABS,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/cmmt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module cmmt_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/complex_matrix_magnitude_transform_unit.sv =====
// Top level of the complex matrix magnitude transform unit; uses cmmt_pkg and cmmt_ram.
// Load items are taken back to back while the sequencer is idle. A run works row by row: it reads
// the N clamped samples of the row (none when the sample range is empty) and accumulates them, then
// takes absolute values, squares, adds and forms a bit-serial root (ROOT_W = 26 at default sizes).
// A result held by rsp_ready stalls the next row at its emit. Requests wait during a run.
// Reset clears the sequencer, the pipeline valid flags and the result valid flag only; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module complex_matrix_magnitude_transform_unit (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire cmmt_pkg::req_payload_type req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output cmmt_pkg::rsp_payload_type     rsp_data
);

   import cmmt_pkg::*;

   // Sequencer state
   state_type state_ff, state_in;

   // Run bounds and counters
   logic [ROW_CNT_W-1:0] row_ff;
   logic [ROW_CNT_W-1:0] r_end_ff;
   logic [SCNT_W-1:0]    s_ff;
   logic [SCNT_W-1:0]    s_start_ff;
   logic [SCNT_W-1:0]    s_end_ff;

   // MAC pipeline
   logic                     rd_vld_ff;
   logic                     prod_vld_ff;
   logic signed [PROD_W-1:0] prod_re_ff;
   logic signed [PROD_W-1:0] prod_im_ff;
   logic signed [ACC_W-1:0]  acc_re_ff;
   logic signed [ACC_W-1:0]  acc_im_ff;

   // Magnitude datapath
   logic [A_W-1:0]    a_ff, b_ff;
   logic [SQ_W-1:0]   sq_a_ff, sq_b_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [RCNT_W-1:0] root_cnt_ff;

   // Result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   // Memory ports
   logic                coef_wr_en;
   logic [CADDR_W-1:0]  coef_wr_addr;
   logic [31:0]         coef_rd_data;
   logic                smp_wr_en;
   logic [SIDX_W-1:0]   smp_wr_addr;
   logic [15:0]         smp_rd_data;
   logic [CADDR_W-1:0]  coef_rd_addr;
   logic [SIDX_W-1:0]   smp_rd_addr;

   // Control
   logic                 accept;
   logic                 run_start;
   logic                 run_nonempty;
   logic [ROW_CNT_W-1:0] r_end_clamp;
   logic [SCNT_W-1:0]    s_end_clamp;
   logic [SCNT_W-1:0]    s_start_clamp;
   logic                 rd_issue;
   logic                 out_free;
   logic                 emit;
   logic                 row_last;
   logic                 next_row;

   // Square-root step
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              root_ge;

   // Shifted sums
   logic signed [A_W-1:0] q_re, q_im;

   //------------------------------------------------------------------
   // Stores: coefficient pair packed as {imag, real}, samples alone
   //------------------------------------------------------------------
   cmmt_ram #(
      .WIDTH (32),
      .DEPTH (CDEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data ({req_data.coef_imag, req_data.coef_real}),
      .rd_en   (rd_issue),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   cmmt_ram #(
      .WIDTH (16),
      .DEPTH (SAMPLES)
   ) u_smp_ram (
      .clock   (clock),
      .wr_en   (smp_wr_en),
      .wr_addr (smp_wr_addr),
      .wr_data (req_data.sample_value),
      .rd_en   (rd_issue),
      .rd_addr (smp_rd_addr),
      .rd_data (smp_rd_data)
   );

   //------------------------------------------------------------------
   // Request decode: clamp the run bounds, route loads to the stores
   //------------------------------------------------------------------
   always_comb begin
      accept = req_valid && req_ready;

      // Clamp row end to ROWS and sample end to SAMPLES
      if (32'(req_data.row_end) > ROWS) begin
         r_end_clamp = ROW_CNT_W'(ROWS);
      end else begin
         r_end_clamp = ROW_CNT_W'(req_data.row_end);
      end
      if (32'(req_data.sample_end) > SAMPLES) begin
         s_end_clamp = SCNT_W'(SAMPLES);
      end else begin
         s_end_clamp = SCNT_W'(req_data.sample_end);
      end
      // A start at or past the end collapses to an empty sample range
      if (32'(req_data.sample_start) < 32'(s_end_clamp)) begin
         s_start_clamp = SCNT_W'(req_data.sample_start);
      end else begin
         s_start_clamp = s_end_clamp;
      end
      run_nonempty = 32'(req_data.row_start) < 32'(r_end_clamp);
      run_start    = accept && (req_data.operation == OP_RUN);

      // Loads beyond the store bounds are dropped
      coef_wr_en = accept && (req_data.operation == OP_LOAD_COEF)
                   && (32'(req_data.load_row) < ROWS)
                   && (32'(req_data.load_column) < SAMPLES);
      smp_wr_en  = accept && (req_data.operation == OP_LOAD_SAMPLE)
                   && (32'(req_data.load_column) < SAMPLES);
      coef_wr_addr = CADDR_W'(32'(req_data.load_row) * SAMPLES
                              + 32'(req_data.load_column));
      smp_wr_addr  = SIDX_W'(req_data.load_column);
   end

   //------------------------------------------------------------------
   // Sequencer outputs
   //------------------------------------------------------------------
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      rd_issue     = (state_ff == ST_MAC) && (s_ff < s_end_ff);
      out_free     = !rsp_valid_ff || rsp_ready;
      emit         = (state_ff == ST_EMIT) && out_free;
      row_last     = ((row_ff + ROW_CNT_W'(1)) == r_end_ff);
      next_row     = emit && !row_last;
      coef_rd_addr = CADDR_W'(32'(row_ff) * SAMPLES + 32'(s_ff));
      smp_rd_addr  = s_ff[SIDX_W-1:0];
   end

   //------------------------------------------------------------------
   // Sequencer next state
   //------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (run_start && run_nonempty) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            // Leave after the last read goes out, or at once on an empty range
            if (!rd_issue || ((s_ff + SCNT_W'(1)) == s_end_ff)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS:    state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_ROOT;
         ST_ROOT: begin
            if (root_cnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = row_last ? ST_IDLE : ST_MAC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   //------------------------------------------------------------------
   // Control registers
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_vld_ff   <= rd_issue;
         prod_vld_ff <= rd_vld_ff;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   //------------------------------------------------------------------
   // Row and sample counters
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (run_start) begin
         // Hold the bounds; row counter starts at the first row
         row_ff     <= ROW_CNT_W'(req_data.row_start);
         r_end_ff   <= r_end_clamp;
         s_start_ff <= s_start_clamp;
         s_end_ff   <= s_end_clamp;
         s_ff       <= s_start_clamp;
      end else if (next_row) begin
         row_ff <= row_ff + ROW_CNT_W'(1);
         s_ff   <= s_start_ff;
      end else if (rd_issue) begin
         s_ff <= s_ff + SCNT_W'(1);
      end
   end

   //------------------------------------------------------------------
   // Multiply-accumulate: product stage, then accumulate stage
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_re_ff <= $signed(smp_rd_data) * $signed(coef_rd_data[15:0]);
         prod_im_ff <= $signed(smp_rd_data) * $signed(coef_rd_data[31:16]);
      end
      if (run_start || next_row) begin
         // Clear the sums at the top of every row
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(prod_re_ff);
         acc_im_ff <= acc_im_ff + ACC_W'(prod_im_ff);
      end
   end

   //------------------------------------------------------------------
   // Magnitude: drop the fraction (floor), take absolute values,
   // square, add, then one root bit per cycle
   //------------------------------------------------------------------
   always_comb begin
      q_re    = $signed(acc_re_ff[ACC_W-1:FRAC_W]);
      q_im    = $signed(acc_im_ff[ACC_W-1:FRAC_W]);
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      root_ge = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_ABS: begin
            a_ff <= q_re[A_W-1] ? A_W'(-q_re) : A_W'(q_re);
            b_ff <= q_im[A_W-1] ? A_W'(-q_im) : A_W'(q_im);
         end
         ST_SQUARE: begin
            sq_a_ff <= SQ_W'(a_ff) * SQ_W'(a_ff);
            sq_b_ff <= SQ_W'(b_ff) * SQ_W'(b_ff);
         end
         ST_SUM: begin
            rad_ff      <= RAD_W'(sq_a_ff) + RAD_W'(sq_b_ff);
            rem_ff      <= '0;
            root_ff     <= '0;
            root_cnt_ff <= RCNT_W'(ROOT_W - 1);
         end
         ST_ROOT: begin
            rad_ff      <= {rad_ff[RAD_W-3:0], 2'b00};
            rem_ff      <= root_ge ? (rem_sh - trial) : rem_sh;
            root_ff     <= {root_ff[ROOT_W-2:0], root_ge};
            root_cnt_ff <= root_cnt_ff - RCNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   //------------------------------------------------------------------
   // Result register: the next row computes while this item waits
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff.row_index <= 6'(row_ff);
         rsp_data_ff.magnitude <= MAG_W'(root_ff);
         rsp_data_ff.last      <= row_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
